>>> design/ecpa_pkg.sv
// ---------------------------------------------------------------------------
// ecpa_pkg
// Shared widths, reset constants and the arithmetic unit's operation codes.
// ---------------------------------------------------------------------------
package ecpa_pkg;

    localparam int unsigned DATA_W         = 64;
    localparam int unsigned FIELD_BITS_DEF = 64;
    localparam int unsigned CFG_IDX_W      = 64;

    localparam logic [DATA_W-1:0] PRIME_RESET = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam logic [DATA_W-1:0] A_RESET     = '0;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_PRIME = 64'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_A     = 64'd1;

    // arithmetic unit operation codes
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_RED = 2'd3
    } alu_op_t;

endpackage

>>> design/ecpa_if.sv
// ---------------------------------------------------------------------------
// ecpa_pt_if / ecpa_sum_if / ecpa_cfg_if
// Valid/ready channels for the point pair, the sum and configuration writes.
// ---------------------------------------------------------------------------
interface ecpa_pt_if;
    logic        valid;
    logic        ready;
    logic [63:0] first_x;
    logic [63:0] first_y;
    logic        first_at_infinity;
    logic [63:0] second_x;
    logic [63:0] second_y;
    logic        second_at_infinity;
    modport source (output valid, first_x, first_y, first_at_infinity,
                    second_x, second_y, second_at_infinity, input ready);
    modport sink   (input valid, first_x, first_y, first_at_infinity,
                    second_x, second_y, second_at_infinity, output ready);
endinterface

interface ecpa_sum_if;
    logic        valid;
    logic        ready;
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    logic        sum_at_infinity;
    modport source (output valid, sum_x, sum_y, sum_at_infinity, input ready);
    modport sink   (input valid, sum_x, sum_y, sum_at_infinity, output ready);
endinterface

interface ecpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ecpa_alu.sv
// ---------------------------------------------------------------------------
// ecpa_alu
// Bit-serial modular unit: multiply (MSB-first double-and-add, one bit per
// cycle), reduce (restoring, one bit per cycle), add and subtract (not serial).
// ---------------------------------------------------------------------------
module ecpa_alu #(
    parameter int unsigned W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ecpa_pkg::alu_op_t op,
    input  logic [W-1:0] u,
    input  logic [W-1:0] v,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] res
);
    import ecpa_pkg::*;

    localparam int unsigned CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    alu_op_t       op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  sh_reg, sh_next;

    // modular add of two reduced values (also used for r+r and r+u)
    function automatic logic [W-1:0] madd(logic [W-1:0] p, logic [W-1:0] q,
                                         logic [W-1:0] mm);
        logic [W:0] s;
        s = {1'b0, p} + {1'b0, q};
        if (s >= {1'b0, mm})
            s = s - {1'b0, mm};
        return s[W-1:0];
    endfunction

    logic [W-1:0] dbl, stepv;
    logic [W:0]   rsh;

    always_comb
    begin
        dbl   = madd(acc_reg, acc_reg, m);
        stepv = sh_reg[W-1] ? madd(dbl, u_reg, m) : dbl;
        rsh   = {acc_reg, sh_reg[W-1]};
    end

    // sequencing of the serial step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        u_next    = u_reg;
        sh_next   = sh_reg;
        if (!busy_reg && start)
        begin
            op_next  = op;
            u_next   = u;
            sh_next  = v;
            cnt_next = CW'(W);
            acc_next = '0;
            unique case (op)
                OP_ADD:
                begin
                    acc_next  = madd(u, v, m);
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    acc_next  = (u >= v) ? (u - v) : (u - v + m);
                    done_next = 1'b1;
                end
                OP_MUL, OP_RED:
                begin
                    busy_next = 1'b1;
                    sh_next   = (op == OP_MUL) ? v : u;
                end
                default: ;
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
                acc_next = stepv;
            else
                acc_next = (rsh >= {1'b0, m}) ? W'(rsh - {1'b0, m}) : rsh[W-1:0];
            sh_next  = {sh_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        u_reg   <= u_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;

endmodule

>>> design/ecpa_seq.sv
// ---------------------------------------------------------------------------
// ecpa_seq
// Micro-program sequencer: reduces inputs, picks the case, drives the serial
// unit through slope, inversion by exponentiation and the result formulas.
// ---------------------------------------------------------------------------
module ecpa_seq #(
    parameter int unsigned W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] m,
    input  logic [W-1:0] a_raw,
    input  logic [W-1:0] x1_raw,
    input  logic [W-1:0] y1_raw,
    input  logic         inf1,
    input  logic [W-1:0] x2_raw,
    input  logic [W-1:0] y2_raw,
    input  logic         inf2,
    output logic         busy,
    output logic         fin,
    output logic [W-1:0] rx,
    output logic [W-1:0] ry,
    output logic         rinf
);
    import ecpa_pkg::*;

    localparam int unsigned EW = $clog2(W + 1);
    localparam int unsigned IW = $clog2(W);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RED   = 10'b00_0000_0010,
        S_CASE  = 10'b00_0000_0100,
        S_NUM   = 10'b00_0000_1000,
        S_INVSQ = 10'b00_0001_0000,
        S_INVML = 10'b00_0010_0000,
        S_SLOPE = 10'b00_0100_0000,
        S_X3    = 10'b00_1000_0000,
        S_Y3    = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t        st_reg, st_next;
    logic [3:0]    ph_reg, ph_next;
    logic          wait_reg, wait_next;
    logic [EW-1:0] eb_reg, eb_next;
    logic          dbl_reg, dbl_next;
    logic [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic [W-1:0]  x1_next, y1_next, x2_next, y2_next, a_next;
    logic          inf1_reg, inf2_reg, inf1_next, inf2_next;
    logic [W-1:0]  t0_reg, t1_reg, t2_reg, t0_next, t1_next, t2_next;
    logic [W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    logic          rinf_reg, rinf_next;

    logic          a_start, a_done;
    alu_op_t       a_op;
    logic [W-1:0]  a_u, a_v, a_res, e;
    logic [EW-1:0] eb_m1;

    assign e     = m - W'(2);
    assign eb_m1 = eb_reg - EW'(1);

    ecpa_alu #(.W(W)) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (a_start),
        .op    (a_op),
        .u     (a_u),
        .v     (a_v),
        .m     (m),
        .done  (a_done),
        .res   (a_res)
    );

    // issue one unit operation per phase, advance when it completes
    always_comb
    begin
        st_next  = st_reg;
        ph_next  = ph_reg;
        wait_next = wait_reg;
        eb_next  = eb_reg;
        dbl_next = dbl_reg;
        x1_next = x1_reg; y1_next = y1_reg; x2_next = x2_reg; y2_next = y2_reg;
        a_next  = a_reg;
        inf1_next = inf1_reg; inf2_next = inf2_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg;
        rx_next = rx_reg; ry_next = ry_reg; rinf_next = rinf_reg;
        a_start = 1'b0;
        a_op    = OP_MUL;
        a_u     = '0;
        a_v     = '0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    x1_next = x1_raw; y1_next = y1_raw;
                    x2_next = x2_raw; y2_next = y2_raw;
                    a_next  = a_raw;
                    inf1_next = inf1; inf2_next = inf2;
                    ph_next = '0;
                    wait_next = 1'b0;
                    st_next = S_RED;
                end
            end
            S_RED:
            begin
                a_op = OP_RED;
                unique case (ph_reg)
                    4'd0: a_u = x1_reg;
                    4'd1: a_u = y1_reg;
                    4'd2: a_u = x2_reg;
                    4'd3: a_u = y2_reg;
                    default: a_u = a_reg;
                endcase
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    unique case (ph_reg)
                        4'd0: x1_next = a_res;
                        4'd1: y1_next = a_res;
                        4'd2: x2_next = a_res;
                        4'd3: y2_next = a_res;
                        default: a_next = a_res;
                    endcase
                    ph_next = ph_reg + 4'd1;
                    if (ph_reg == 4'd4)
                        st_next = S_CASE;
                end
            end
            S_CASE:
            begin
                rinf_next = 1'b1;
                rx_next   = '0;
                ry_next   = '0;
                ph_next   = '0;
                wait_next = 1'b0;
                if (inf1_reg && inf2_reg)
                    st_next = S_DONE;
                else if (inf1_reg)
                begin
                    rx_next = x2_reg; ry_next = y2_reg; rinf_next = 1'b0;
                    st_next = S_DONE;
                end
                else if (inf2_reg)
                begin
                    rx_next = x1_reg; ry_next = y1_reg; rinf_next = 1'b0;
                    st_next = S_DONE;
                end
                else if (x1_reg == x2_reg && (y1_reg != y2_reg || y1_reg == '0))
                    st_next = S_DONE;
                else
                begin
                    dbl_next = (x1_reg == x2_reg);
                    st_next  = S_NUM;
                end
            end
            // t0 = numerator, t1 = denominator
            S_NUM:
            begin
                if (dbl_reg)
                begin
                    unique case (ph_reg)
                        4'd0: begin a_op = OP_MUL; a_u = x1_reg; a_v = x1_reg; end
                        4'd1: begin a_op = OP_ADD; a_u = t0_reg; a_v = t0_reg; end
                        4'd2: begin a_op = OP_ADD; a_u = t0_reg; a_v = t1_reg; end
                        4'd3: begin a_op = OP_ADD; a_u = t0_reg; a_v = a_reg; end
                        default: begin a_op = OP_ADD; a_u = y1_reg; a_v = y1_reg; end
                    endcase
                end
                else
                begin
                    a_op = OP_SUB;
                    if (ph_reg == 4'd0)
                    begin
                        a_u = y2_reg; a_v = y1_reg;
                    end
                    else
                    begin
                        a_u = x2_reg; a_v = x1_reg;
                    end
                end
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    ph_next = ph_reg + 4'd1;
                    if (dbl_reg)
                    begin
                        unique case (ph_reg)
                            4'd0: begin t0_next = a_res; t1_next = a_res; end
                            4'd1, 4'd2, 4'd3: t0_next = a_res;
                            default: t1_next = a_res;
                        endcase
                    end
                    else if (ph_reg == 4'd0)
                        t0_next = a_res;
                    else
                        t1_next = a_res;
                    if ((dbl_reg && ph_reg == 4'd4) || (!dbl_reg && ph_reg == 4'd1))
                    begin
                        // inverse: t2 = t1^(m-2), MSB-first square and multiply
                        t2_next = W'(1);
                        eb_next = EW'(W);
                        ph_next = '0;
                        st_next = S_INVSQ;
                    end
                end
            end
            S_INVSQ:
            begin
                a_op = OP_MUL; a_u = t2_reg; a_v = t2_reg;
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    t2_next = a_res;
                    if (e[eb_m1[IW-1:0]])
                        st_next = S_INVML;
                    else if (eb_reg == EW'(1))
                        st_next = S_SLOPE;
                    else
                        eb_next = eb_reg - EW'(1);
                end
            end
            S_INVML:
            begin
                a_op = OP_MUL; a_u = t2_reg; a_v = t1_reg;
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    t2_next = a_res;
                    if (eb_reg == EW'(1))
                        st_next = S_SLOPE;
                    else
                    begin
                        eb_next = eb_reg - EW'(1);
                        st_next = S_INVSQ;
                    end
                end
            end
            // s = num * inv into t0
            S_SLOPE:
            begin
                a_op = OP_MUL; a_u = t0_reg; a_v = t2_reg;
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    t0_next = a_res;
                    ph_next = '0;
                    st_next = S_X3;
                end
            end
            // x3 = s*s - x1 - x2 into rx
            S_X3:
            begin
                unique case (ph_reg)
                    4'd0: begin a_op = OP_MUL; a_u = t0_reg; a_v = t0_reg; end
                    4'd1: begin a_op = OP_SUB; a_u = rx_reg; a_v = x1_reg; end
                    default: begin a_op = OP_SUB; a_u = rx_reg; a_v = x2_reg; end
                endcase
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    rx_next = a_res;
                    ph_next = ph_reg + 4'd1;
                    if (ph_reg == 4'd2)
                    begin
                        ph_next = '0;
                        st_next = S_Y3;
                    end
                end
            end
            // y3 = s*(x1 - x3) - y1 into ry
            S_Y3:
            begin
                unique case (ph_reg)
                    4'd0: begin a_op = OP_SUB; a_u = x1_reg; a_v = rx_reg; end
                    4'd1: begin a_op = OP_MUL; a_u = t0_reg; a_v = ry_reg; end
                    default: begin a_op = OP_SUB; a_u = ry_reg; a_v = y1_reg; end
                endcase
                a_start = !wait_reg;
                wait_next = 1'b1;
                if (a_done)
                begin
                    wait_next = 1'b0;
                    ry_next = a_res;
                    ph_next = ph_reg + 4'd1;
                    if (ph_reg == 4'd2)
                    begin
                        rinf_next = 1'b0;
                        st_next = S_DONE;
                    end
                end
            end
            S_DONE:
                st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ph_reg   <= '0;
            wait_reg <= 1'b0;
            eb_reg   <= '0;
            dbl_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            wait_reg <= wait_next;
            eb_reg   <= eb_next;
            dbl_reg  <= dbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x1_next; y1_reg <= y1_next;
        x2_reg <= x2_next; y2_reg <= y2_next;
        a_reg  <= a_next;
        inf1_reg <= inf1_next; inf2_reg <= inf2_next;
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next;
        rx_reg <= rx_next; ry_reg <= ry_next; rinf_reg <= rinf_next;
    end

    assign busy = (st_reg != S_IDLE);
    assign fin  = (st_reg == S_DONE);
    assign rx   = rx_reg;
    assign ry   = ry_reg;
    assign rinf = rinf_reg;

endmodule

>>> design/ec_affine_point_add.sv
// Work: with a slope, the inversion squarings dominate the run from accept to
//   sum beat; without, only the input reductions run on the serial unit.
// Throughput: one pair at a time, none accepted until the sum is taken;
//   set by the one-bit-per-cycle modular unit.
// Reset: rst_n async low clears control; prime and a return to reset values.
// ---------------------------------------------------------------------------
// ec_affine_point_add
// Affine point addition over a prime field with a bit-serial modular unit.
// ---------------------------------------------------------------------------
module ec_affine_point_add #(
    parameter int unsigned FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ecpa_pt_if.sink    pts,
    ecpa_sum_if.source sum,
    ecpa_cfg_if.sink   cfg
);
    import ecpa_pkg::*;

    localparam int unsigned W = FIELD_BITS;

    logic [DATA_W-1:0] prime_reg, prime_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic              ov_reg, ov_next;
    logic [DATA_W-1:0] ox_reg, oy_reg;
    logic              oinf_reg;
    logic [W-1:0]      m_eff, rx, ry;
    logic              busy, fin, rinf, go;

    // configuration writes
    assign cfg.ready = 1'b1;
    always_comb
    begin
        prime_next = prime_reg;
        a_next     = a_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_FIELD_PRIME)
                prime_next = cfg.data;
            else if (cfg.index == REG_CURVE_A)
                a_next = cfg.data;
        end
    end

    assign m_eff = (prime_reg[W-1:0] < W'(3)) ? W'(3) : prime_reg[W-1:0];

    assign pts.ready = !busy && !ov_reg;
    assign go        = pts.valid && pts.ready;

    ecpa_seq #(.W(W)) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .m      (m_eff),
        .a_raw  (a_reg[W-1:0]),
        .x1_raw (pts.first_x[W-1:0]),
        .y1_raw (pts.first_y[W-1:0]),
        .inf1   (pts.first_at_infinity),
        .x2_raw (pts.second_x[W-1:0]),
        .y2_raw (pts.second_y[W-1:0]),
        .inf2   (pts.second_at_infinity),
        .busy   (busy),
        .fin    (fin),
        .rx     (rx),
        .ry     (ry),
        .rinf   (rinf)
    );

    // output register
    always_comb
    begin
        ov_next = ov_reg;
        if (sum.valid && sum.ready)
            ov_next = 1'b0;
        if (fin)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= PRIME_RESET;
            a_reg     <= A_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            prime_reg <= prime_next;
            a_reg     <= a_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            ox_reg   <= DATA_W'(rx);
            oy_reg   <= DATA_W'(ry);
            oinf_reg <= rinf;
        end
    end

    assign sum.valid           = ov_reg;
    assign sum.sum_x           = ox_reg;
    assign sum.sum_y           = oy_reg;
    assign sum.sum_at_infinity = oinf_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pts.ready) else $error("accept while busy");
    a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> sum.valid) else $error("result lost");
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sum.valid && sum.sum_at_infinity) |-> (sum.sum_x == '0 && sum.sum_y == '0))
        else $error("infinity with nonzero coordinates");
`endif

endmodule
